// File: sv/set_assoc_lru_cache_sim_macros.svh
// assertion macros used by the checker module
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SALC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SALC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/salc_pkg.sv
package salc_pkg;

    // way index as carried between modules, wide enough for the largest way count
    localparam int WAY_IDX_W = 4;
    // way count after clamping, holds up to sixteen
    localparam int WAY_CNT_W = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd1;
    localparam logic [CFG_DATA_W-1:0] SET_INDEX_BITS_RESET = 3'd4;
    localparam logic [CFG_DATA_W-1:0] WAYS_IN_USE_RESET    = 3'd4;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } salc_state_t;

    // outcome of one set lookup
    typedef struct packed {
        logic                 hit;
        logic                 evict;
        logic [WAY_IDX_W-1:0] way;
    } salc_result_t;

endpackage

// File: sv/set_assoc_lru_cache_sim.sv
// set-associative cache directory with least-recently-used replacement
// input channel: in_valid / in_stall carry one word, a block number
// output channel: out_valid / out_stall carry hit, way_used, evicted and the
//   running hit and miss counts (saturating at all ones)
// config port: cfg_we, cfg_index, cfg_wdata; index 0 sets the number of set
//   index bits, index 1 the ways in use, other indexes are ignored
// each word is first read, taking the set row from the row ram, then looked up:
//   compare tags, update ranks and write the row back; the next word is taken
//   once the write has landed, so there are no same-set hazards
// a word accepted in idle has its result in the output register when its lookup ends
// after reset a clearing pass writes every row to zero while in_stall stays
//   high; config writes are taken during the pass
// a stalled result holds in the output register; a new word can still be
//   taken at the edge where the pending result is taken
module set_assoc_lru_cache_sim #(
    parameter int SETS       = 16,
    parameter int WAYS       = 4,
    parameter int BLOCK_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [BLOCK_BITS-1:0]           block_number,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [1:0]                      way_used,
    output logic                            evicted,
    output logic [31:0]                     hits_so_far,
    output logic [31:0]                     misses_so_far,
    // configuration
    input  logic                            cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int KMAX   = $clog2(SETS + 1) - 1;
    localparam int AW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W  = WAYS * (1 + AW + BLOCK_BITS);
    localparam int EXT_W  = (SW > BLOCK_BITS) ? SW : BLOCK_BITS;

    salc_pkg::salc_state_t state_reg, state_next;

    logic [SW-1:0]         clr_addr_reg, clr_addr_next;
    logic [BLOCK_BITS-1:0] blk_reg;
    logic [SW-1:0]         set_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg;
    logic [1:0]            way_reg;
    logic                  evict_reg;
    logic [31:0]           hit_cnt_reg, hit_cnt_next;
    logic [31:0]           miss_cnt_reg, miss_cnt_next;
    logic [salc_pkg::CFG_DATA_W-1:0] set_bits_reg, ways_reg;

    logic                  in_take;
    logic                  out_take;
    logic [3:0]            k_eff;
    logic [salc_pkg::WAY_CNT_W-1:0] n_eff;
    logic [EXT_W-1:0]      blk_ext;
    logic [SW-1:0]         set_addr;

    logic                  mem_we;
    logic [SW-1:0]         mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;
    logic [ROW_W-1:0]      row_rd;
    logic [ROW_W-1:0]      row_wr;
    salc_pkg::salc_result_t lk_res;

    // handshakes
    assign out_take = out_valid_reg && !out_stall;
    assign in_take  = in_valid && !in_stall;

    // clamp the config to what the geometry supports
    always_comb
    begin
        if ({1'b0, set_bits_reg} > 4'(KMAX))
        begin
            k_eff = 4'(KMAX);
        end
        else
        begin
            k_eff = {1'b0, set_bits_reg};
        end
        if (ways_reg == '0)
        begin
            n_eff = salc_pkg::WAY_CNT_W'(1);
        end
        else if ({2'b00, ways_reg} > salc_pkg::WAY_CNT_W'(WAYS))
        begin
            n_eff = salc_pkg::WAY_CNT_W'(WAYS);
        end
        else
        begin
            n_eff = {2'b00, ways_reg};
        end
    end

    // set = low k bits of the block number
    assign blk_ext = EXT_W'(block_number);
    always_comb
    begin
        for (int b = 0; b < SW; b++)
        begin
            set_addr[b] = blk_ext[b] && (b < int'(k_eff));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            salc_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == SW'(SETS - 1))
                begin
                    state_next = salc_pkg::ST_IDLE;
                end
            end
            salc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = salc_pkg::ST_LOOKUP;
                end
            end
            salc_pkg::ST_LOOKUP:
            begin
                state_next = salc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = salc_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs: stall, ram write, counters, result register
    always_comb
    begin
        in_stall       = 1'b1;
        mem_we         = 1'b0;
        mem_waddr      = set_reg;
        mem_wdata      = row_wr;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && !out_take;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        case (state_reg)
            salc_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + SW'(1);
            end
            salc_pkg::ST_IDLE:
            begin
                // the result slot is free or is emptied at this edge
                in_stall = out_valid_reg && out_stall;
            end
            salc_pkg::ST_LOOKUP:
            begin
                mem_we         = 1'b1;
                out_valid_next = 1'b1;
                if (lk_res.hit)
                begin
                    if (hit_cnt_reg != salc_pkg::COUNT_MAX)
                    begin
                        hit_cnt_next = hit_cnt_reg + 32'd1;
                    end
                end
                else if (miss_cnt_reg != salc_pkg::COUNT_MAX)
                begin
                    miss_cnt_next = miss_cnt_reg + 32'd1;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= salc_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            set_bits_reg  <= salc_pkg::SET_INDEX_BITS_RESET;
            ways_reg      <= salc_pkg::WAYS_IN_USE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    salc_pkg::CFG_SET_INDEX_BITS: set_bits_reg <= cfg_wdata;
                    salc_pkg::CFG_WAYS_IN_USE:    ways_reg     <= cfg_wdata;
                    default:                      ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            blk_reg <= block_number;
            set_reg <= set_addr;
        end
        if (state_reg == salc_pkg::ST_LOOKUP)
        begin
            hit_reg   <= lk_res.hit;
            way_reg   <= lk_res.way[1:0];
            evict_reg <= lk_res.evict;
        end
    end

    salc_row_ram #(
        .DEPTH  (SETS),
        .ADDR_W (SW),
        .WIDTH  (ROW_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_take),
        .raddr (set_addr),
        .rdata (row_rd)
    );

    salc_lookup #(
        .WAYS       (WAYS),
        .BLOCK_BITS (BLOCK_BITS),
        .AW         (AW),
        .ROW_W      (ROW_W)
    ) u_lookup (
        .row_rd (row_rd),
        .blk    (blk_reg),
        .n_ways (n_eff),
        .row_wr (row_wr),
        .result (lk_res)
    );

    // counters only move after the pending result has been taken
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign way_used      = way_reg;
    assign evicted       = evict_reg;
    assign hits_so_far   = hit_cnt_reg;
    assign misses_so_far = miss_cnt_reg;

endmodule

// File: sv/salc_row_ram.sv
module salc_row_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WIDTH  = 108
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/salc_lookup.sv
module salc_lookup #(
    parameter int WAYS       = 4,
    parameter int BLOCK_BITS = 24,
    parameter int AW         = 2,
    parameter int ROW_W      = 4 * (1 + 2 + 24)
) (
    input  logic [ROW_W-1:0]               row_rd,
    input  logic [BLOCK_BITS-1:0]          blk,
    input  logic [salc_pkg::WAY_CNT_W-1:0] n_ways,
    output logic [ROW_W-1:0]               row_wr,
    output salc_pkg::salc_result_t         result
);

    localparam int SLOT_W = 1 + AW + BLOCK_BITS;
    localparam logic [AW-1:0] AGE_MAX = AW'(WAYS - 1);

    logic [WAYS-1:0][SLOT_W-1:0] slot_rd;
    logic [WAYS-1:0][SLOT_W-1:0] slot_wr;
    logic [WAYS-1:0][BLOCK_BITS-1:0] tag;
    logic [WAYS-1:0][AW-1:0] age;
    logic [WAYS-1:0] vld;
    logic [WAYS-1:0] in_use;

    logic                           hit_found;
    logic                           empty_found;
    logic [salc_pkg::WAY_IDX_W-1:0] hit_way;
    logic [salc_pkg::WAY_IDX_W-1:0] empty_way;
    logic [salc_pkg::WAY_IDX_W-1:0] lru_way;
    logic [salc_pkg::WAY_IDX_W-1:0] sel_way;
    logic [AW-1:0]                  oldest;
    logic [AW-1:0]                  mine;
    logic [AW-1:0]                  age_new;
    logic                           bump;

    assign slot_rd = row_rd;
    assign row_wr  = slot_wr;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            tag[w]    = slot_rd[w][BLOCK_BITS-1:0];
            age[w]    = slot_rd[w][BLOCK_BITS+AW-1:BLOCK_BITS];
            vld[w]    = slot_rd[w][SLOT_W-1];
            in_use[w] = (salc_pkg::WAY_CNT_W'(w) < n_ways);
        end
    end

    // first matching way, first empty way, first of the oldest ways
    always_comb
    begin
        hit_found   = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        oldest      = age[0];
        lru_way     = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_found && in_use[w] && vld[w] && tag[w] == blk)
            begin
                hit_found = 1'b1;
                hit_way   = salc_pkg::WAY_IDX_W'(w);
            end
            if (!empty_found && in_use[w] && !vld[w])
            begin
                empty_found = 1'b1;
                empty_way   = salc_pkg::WAY_IDX_W'(w);
            end
        end
        for (int w = 1; w < WAYS; w++)
        begin
            if (in_use[w] && age[w] > oldest)
            begin
                oldest  = age[w];
                lru_way = salc_pkg::WAY_IDX_W'(w);
            end
        end
    end

    always_comb
    begin
        if (hit_found)
        begin
            sel_way = hit_way;
        end
        else if (empty_found)
        begin
            sel_way = empty_way;
        end
        else
        begin
            sel_way = lru_way;
        end
        result.hit   = hit_found;
        result.evict = !hit_found && !empty_found;
        result.way   = sel_way;
    end

    // rank update: the chosen way becomes most recent, younger valid ways age by one (all valid ways on an empty fill)
    always_comb
    begin
        mine    = '0;
        bump    = 1'b0;
        age_new = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (salc_pkg::WAY_IDX_W'(w) == sel_way)
            begin
                mine = age[w];
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            slot_wr[w] = slot_rd[w];
            bump = in_use[w] && vld[w] && (salc_pkg::WAY_IDX_W'(w) != sel_way)
                && ((!hit_found && empty_found) || age[w] < mine);
            age_new = (age[w] >= AGE_MAX) ? AGE_MAX : age[w] + AW'(1);
            if (salc_pkg::WAY_IDX_W'(w) == sel_way)
            begin
                slot_wr[w] = {1'b1, {AW{1'b0}}, blk};
            end
            else if (bump)
            begin
                slot_wr[w] = {vld[w], age_new, tag[w]};
            end
        end
    end

endmodule

// File: sv/salc_checker.sv
`include "set_assoc_lru_cache_sim_macros.svh"

module salc_checker #(
    parameter int BLOCK_BITS = 24
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [BLOCK_BITS-1:0] block_number,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  hit,
    input logic [1:0]            way_used,
    input logic                  evicted,
    input logic [31:0]           hits_so_far,
    input logic [31:0]           misses_so_far
);

    logic        in_take;
    logic [67:0] out_word;

    assign in_take  = in_valid && !in_stall;
    assign out_word = {hit, way_used, evicted, hits_so_far, misses_so_far};

    // a stalled input word holds until taken
    `SALC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(block_number), "input word changed while stalled")

    // a stalled result word holds
    `SALC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")

    // a hit never replaces a block
    `SALC_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !evicted, "hit reported with eviction")

    // only one word in flight: busy right after taking a word
    `SALC_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "second word taken during lookup")

    // every accepted word yields a valid result once its lookup is done
    `SALC_ASSERT_NOW(a_result_latency, in_take, ##2 out_valid, "result missing after lookup")

endmodule

bind set_assoc_lru_cache_sim salc_checker #(
    .BLOCK_BITS (BLOCK_BITS)
) u_salc_checker (.*);

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // geometry of the instance under test
    localparam int SETS         = 16;
    localparam int WAYS         = 4;
    localparam int BLOCK_BITS   = 24;
    // largest k with 2^k <= SETS
    localparam int MAX_SET_BITS = 4;
    localparam int RANK_MAX     = WAYS - 1;

    // register indexes the block does not decode
    localparam logic [salc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [salc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // traffic shaping
    localparam int IDLE_PCT      = 23;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 120;
    localparam int STALL_LIMIT   = 2000;

    // one looked-up result word
    typedef struct packed {
        logic                 hit;
        logic [1:0]           way;
        logic                 evicted;
        logic [31:0]          hits;
        logic [31:0]          misses;
    } access_outcome_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [BLOCK_BITS-1:0] block_number = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic                  hit;
    logic [1:0]            way_used;
    logic                  evicted;
    logic [31:0]           hits_so_far;
    logic [31:0]           misses_so_far;
    logic                  cfg_we       = 1'b0;
    logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow copy of the cache directory, all clear like the block after reset
    bit [BLOCK_BITS-1:0]   dir_tag   [SETS][WAYS];
    bit                    dir_valid [SETS][WAYS];
    bit [1:0]              dir_rank  [SETS][WAYS];
    bit [31:0]             hit_total;
    bit [31:0]             miss_total;
    bit [salc_pkg::CFG_DATA_W-1:0] set_bits_reg = salc_pkg::SET_INDEX_BITS_RESET;
    bit [salc_pkg::CFG_DATA_W-1:0] ways_reg     = salc_pkg::WAYS_IN_USE_RESET;

    // lookups the block still owes us, oldest first
    access_outcome_t       pending_outcomes [$];
    int unsigned           errors = 0;

    // no idling on either side while set
    bit                    calm = 1'b0;
    // a bump here asks the receiver for one long hold-off
    int unsigned           hold_requests = 0;

    set_assoc_lru_cache_sim #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .BLOCK_BITS (BLOCK_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .block_number  (block_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .way_used      (way_used),
        .evicted       (evicted),
        .hits_so_far   (hits_so_far),
        .misses_so_far (misses_so_far),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // recency rank grows by one, pinned at the oldest rank
    function automatic logic [1:0] aged(input logic [1:0] r);
        return (r >= RANK_MAX) ? 2'(RANK_MAX) : r + 2'd1;
    endfunction

    // look one block up in the shadow directory and update it like the block does
    function automatic access_outcome_t cache_lookup(input logic [BLOCK_BITS-1:0] blk);
        int unsigned     k;
        int unsigned     n;
        int unsigned     s;
        int unsigned     w;
        int unsigned     way;
        bit              found;
        bit              empty;
        logic [1:0]      mine;
        logic [1:0]      oldest;
        access_outcome_t o;
        o     = '0;
        found = 1'b0;
        empty = 1'b0;
        way   = 0;
        // too many index bits clamp to the sets we have
        k = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
        // zero ways acts as one, too many as all
        n = ways_reg;
        if (n < 1)
            n = 1;
        if (n > WAYS)
            n = WAYS;
        s = blk & ((1 << k) - 1);

        for (w = 0; w < n && !found; w++)
        begin
            if (dir_valid[s][w] && dir_tag[s][w] == blk)
            begin
                way   = w;
                found = 1'b1;
            end
        end

        if (found)
        begin
            // younger valid ways age, the hit way becomes newest
            mine = dir_rank[s][way];
            for (w = 0; w < n; w++)
                if (w != way && dir_valid[s][w] && dir_rank[s][w] < mine)
                    dir_rank[s][w] = aged(dir_rank[s][w]);
            dir_rank[s][way] = 2'd0;
            hit_total = (hit_total == salc_pkg::COUNT_MAX) ? hit_total : hit_total + 1;
        end
        else
        begin
            for (w = 0; w < n && !empty; w++)
            begin
                if (!dir_valid[s][w])
                begin
                    way   = w;
                    empty = 1'b1;
                end
            end
            if (empty)
            begin
                // fill of an empty way ages every valid way in use
                for (w = 0; w < n; w++)
                    if (dir_valid[s][w])
                        dir_rank[s][w] = aged(dir_rank[s][w]);
            end
            else
            begin
                // oldest way goes, ties pick the lowest way number
                oldest = dir_rank[s][0];
                way    = 0;
                for (w = 1; w < n; w++)
                begin
                    if (dir_rank[s][w] > oldest)
                    begin
                        oldest = dir_rank[s][w];
                        way    = w;
                    end
                end
                mine = dir_rank[s][way];
                for (w = 0; w < n; w++)
                    if (w != way && dir_rank[s][w] < mine)
                        dir_rank[s][w] = aged(dir_rank[s][w]);
                o.evicted = 1'b1;
            end
            dir_tag[s][way]   = blk;
            dir_valid[s][way] = 1'b1;
            dir_rank[s][way]  = 2'd0;
            miss_total = (miss_total == salc_pkg::COUNT_MAX) ? miss_total : miss_total + 1;
        end

        o.hit    = found;
        o.way    = 2'(way);
        o.hits   = hit_total;
        o.misses = miss_total;
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // every accepted input word gets its expectation at the edge it is taken
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pending_outcomes.push_back(cache_lookup(block_number));
    end

    // every accepted result word is held against the oldest expectation
    always @(posedge clk)
    begin : result_check
        access_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing expected, expected none actual hit=%0b",
                         $time, hit);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("hit", want.hit, hit);
                check_field("way_used", want.way, way_used);
                check_field("evicted", want.evicted, evicted);
                check_field("hits_so_far", want.hits, hits_so_far);
                check_field("misses_so_far", want.misses, misses_so_far);
            end
        end
    end

    // receiver: random stall, or one long hold-off when a test asks
    initial
    begin : receiver
        int unsigned holds_served;
        int unsigned hold_left;
        holds_served = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // give up once nothing moves on either channel for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // offer one word, maybe after a random gap, and hold it until taken
    task automatic access_block(input logic [BLOCK_BITS-1:0] blk);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        block_number <= blk;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait for every owed result, then a little longer
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [salc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [salc_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            salc_pkg::CFG_SET_INDEX_BITS: set_bits_reg = val;
            salc_pkg::CFG_WAYS_IN_USE:    ways_reg     = val;
            default: ;  // unknown index, dropped
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // both registers, only once the block is quiet
    task automatic configure(input logic [salc_pkg::CFG_DATA_W-1:0] set_bits,
                             input logic [salc_pkg::CFG_DATA_W-1:0] ways);
        settle();
        write_reg(salc_pkg::CFG_SET_INDEX_BITS, set_bits);
        write_reg(salc_pkg::CFG_WAYS_IN_USE, ways);
    endtask

    // reset settings: 16 sets, 4 ways
    task automatic test_directed_lookups();
        access_block(24'h000000);   // cold miss, set 0 way 0
        access_block(24'hFFFFFF);   // all ones, set 15
        access_block(24'h000000);   // first hit
        access_block(24'h000010);   // fill set 0 way 1
        access_block(24'h000020);   // way 2
        access_block(24'h000030);   // way 3, set 0 full
        access_block(24'h000000);   // hit refreshes way 0
        access_block(24'h000040);   // evict lru, way 1
        access_block(24'h000010);   // just evicted, misses again
        access_block(24'hAAAAAA);   // alternating bits
        access_block(24'h555555);
        access_block(24'hFFFFFF);   // hit in set 15
        access_block(24'hFFFFF0);   // set 0, evict again
        access_block(24'h800000);   // top bit only, set 0
        access_block(24'h000040);   // recent fill, hits
        settle();
    endtask

    // every value of every register, spare indexes too
    task automatic test_register_settings();
        int unsigned v;
        // writes to undecoded indexes change nothing
        settle();
        write_reg(CFG_SPARE_A, 3'd7);
        write_reg(CFG_SPARE_B, 3'd0);
        write_reg(CFG_SPARE_A, 3'd0);
        write_reg(CFG_SPARE_B, 3'd7);
        repeat (6)
            access_block(BLOCK_BITS'($urandom_range(0, 63)));
        // set bits walk up while ways walk down, clamps at both ends
        for (v = 0; v < 8; v++)
        begin
            configure(3'(v), 3'(7 - v));
            repeat (8)
                access_block(BLOCK_BITS'($urandom_range(0, 63)));
        end
        settle();
    endtask

    // shrink then widen the ways so stale and equal ranks meet
    task automatic test_stale_ranks();
        int unsigned b;
        configure(3'd0, 3'd4);      // single set
        for (b = 100; b < 104; b++)
            access_block(BLOCK_BITS'(b));
        configure(3'd0, 3'd2);      // ways 2 and 3 sit untouched
        for (b = 104; b < 107; b++)
            access_block(BLOCK_BITS'(b));
        access_block(24'd105);
        configure(3'd0, 3'd4);      // old ranks of ways 2, 3 come back in play
        access_block(24'd102);      // hit in a way left out for a while
        for (b = 107; b < 112; b++)
            access_block(BLOCK_BITS'(b));
        access_block(24'd103);
        settle();
    endtask

    // well-formed traffic: a working set that fits partly, plus noise
    task automatic test_random_traffic(input int unsigned total);
        int unsigned           phase;
        int unsigned           per_phase;
        int unsigned           pool_size;
        logic [BLOCK_BITS-1:0] pool [$];
        per_phase = total / 6;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       configure(3'd7, 3'd7);   // both over range
                1:       configure(3'd0, 3'd0);   // one set, one way
                2:       configure(3'd4, 3'd4);
                default: configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            endcase
            pool.delete();
            pool_size = $urandom_range(3, 96);
            repeat (pool_size)
                pool.push_back(BLOCK_BITS'($urandom()));
            repeat (per_phase)
            begin
                if ($urandom_range(99) < 75)
                    access_block(pool[$urandom_range(0, pool_size - 1)]);
                else
                    access_block(BLOCK_BITS'($urandom()));
            end
        end
        settle();
    endtask

    // long receiver hold-off fills the block, then the sender waits it out
    task automatic test_output_backpressure();
        configure(3'd4, 3'd4);
        hold_requests++;
        repeat (40)
            access_block(BLOCK_BITS'($urandom_range(0, 255)));
        settle();
        repeat (20)
            access_block(BLOCK_BITS'($urandom_range(0, 255)));
        settle();
    endtask

    // back to back words, never a stall from our side
    task automatic test_no_idle_stretch();
        configure(3'd3, 3'd4);
        calm = 1'b1;
        repeat (150)
            access_block(BLOCK_BITS'($urandom_range(0, 127)));
        settle();
        calm = 1'b0;
    endtask

    initial
    begin
        // hold reset, then the clearing pass holds in_stall high
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed_lookups();
        test_register_settings();
        test_stale_ranks();
        test_random_traffic(900);
        test_output_backpressure();
        test_no_idle_stretch();
        settle();

        if (pending_outcomes.size() != 0)
        begin
            errors++;
            $display("%0t: results never arrived, expected %0d more actual 0",
                     $time, pending_outcomes.size());
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
